// ----- hw/rtl/positional_ordered_list_assert.svh -----
// ----------------------------------------------------------------------------
// positional_ordered_list_assert.svh
// Assertion macros for the positional ordered list; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_ORDERED_LIST_ASSERT_SVH
`define POSITIONAL_ORDERED_LIST_ASSERT_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge out of reset.
`define POL_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true out of reset.
`define POL_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    `POL_ASSERT(label, clk, rst_n, !(cond), msg)

`else

`define POL_ASSERT(label, clk, rst_n, prop, msg)
`define POL_ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

// ----- hw/rtl/pol_pkg.sv -----
// ----------------------------------------------------------------------------
// pol_pkg
// Shared widths, request codes and cell control bundle.
// ----------------------------------------------------------------------------
package pol_pkg;

    localparam int KIND_W = 3;
    localparam int DATA_W = 8;
    localparam int POS_W  = 8;

    typedef enum logic [KIND_W-1:0] {
        REQ_INSERT = 3'd0,
        REQ_DELETE = 3'd1,
        REQ_GET    = 3'd2,
        REQ_LOCATE = 3'd3,
        REQ_CLEAR  = 3'd4
    } t_req_kind;

    // Broadcast to every cell in the chain each cycle.
    typedef struct packed {
        logic              ins;      // insert: cell at pos takes value, later cells shift up
        logic              del;      // delete: cells from pos on take right neighbor
        logic [POS_W-1:0]  pos_idx;  // zero-based position
        logic [DATA_W-1:0] value;    // insert data / locate key
        logic [POS_W-1:0]  count;    // current occupancy, qualifies match
    } t_cell_ctrl;

endpackage

// ----- hw/rtl/pol_req_if.sv -----
// ----------------------------------------------------------------------------
// pol_req_if
// Request channel: valid/ready with request kind, position and value.
// ----------------------------------------------------------------------------
interface pol_req_if;

    logic                        valid;
    logic                        ready;
    logic [pol_pkg::KIND_W-1:0]  req_type;
    logic [pol_pkg::POS_W-1:0]   position;
    logic [pol_pkg::DATA_W-1:0]  item_value;

    modport source (output valid, output req_type, output position, output item_value,
                    input ready);
    modport sink   (input valid, input req_type, input position, input item_value,
                    output ready);

endinterface

// ----- hw/rtl/pol_rsp_if.sv -----
// ----------------------------------------------------------------------------
// pol_rsp_if
// Response channel: valid/ready with outcome and occupancy fields.
// ----------------------------------------------------------------------------
interface pol_rsp_if;

    logic                        valid;
    logic                        ready;
    logic                        success;
    logic [pol_pkg::DATA_W-1:0]  read_value;
    logic [pol_pkg::POS_W-1:0]   found_position;
    logic [pol_pkg::POS_W-1:0]   list_length;
    logic                        list_empty;

    modport source (output valid, output success, output read_value,
                    output found_position, output list_length, output list_empty,
                    input ready);
    modport sink   (input valid, input success, input read_value,
                    input found_position, input list_length, input list_empty,
                    output ready);

endinterface

// ----- hw/rtl/positional_ordered_list.sv -----
// ----------------------------------------------------------------------------
// positional_ordered_list
// Bounded ordered byte list with 1-based positions: insert, delete, get,
// locate and clear, one response per request.
// ----------------------------------------------------------------------------
// The list lives in a row of LIST_DEPTH cells, one byte each. In the cycle a
// request transfer happens, every cell looks at its neighbors and the shared
// control bundle: an insert makes the cell at the position take the new byte
// and every later cell take its left neighbor; a delete makes every cell from
// the position on take its right neighbor. All cells compare their byte with
// the key at the same time, so locate needs no walk through the list. A
// request can be taken every cycle while the response path has room. Each
// response passes the first stage, which holds the selected byte and match
// vector, and the second, which encodes the first match and fills the output
// register. The output register and the stage ahead of it keep up to two
// responses. While either of them has room, requests keep flowing with ready
// low on the response side; once both are full, request ready drops in the
// same cycle that response ready is low.
// Slot contents are not reset; the list starts empty and only occupied slots
// are ever reported.
// ----------------------------------------------------------------------------
`include "positional_ordered_list_assert.svh"

module positional_ordered_list #(
    parameter int LIST_DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pol_req_if.sink   i_req,
    pol_rsp_if.source o_rsp
);

    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(LIST_DEPTH);

    // ------------------------------------------------------------------
    // Occupancy and request decode
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    logic                       w_accept;
    logic                       w_pos_nz;
    logic [pol_pkg::POS_W:0]    w_pos_ext;
    logic [pol_pkg::POS_W:0]    w_cnt_ext;
    logic                       w_ins_ok;
    logic                       w_rd_ok;
    logic                       w_ok;
    logic                       w_is_ins;
    logic                       w_is_del;
    logic                       w_is_get;
    logic                       w_is_loc;
    logic                       w_is_clr;

    assign w_accept  = i_req.valid && i_req.ready;
    assign w_pos_nz  = (i_req.position != '0);
    assign w_pos_ext = {1'b0, i_req.position};
    assign w_cnt_ext = (pol_pkg::POS_W + 1)'(r_count);

    assign w_is_ins = (i_req.req_type == pol_pkg::REQ_INSERT);
    assign w_is_del = (i_req.req_type == pol_pkg::REQ_DELETE);
    assign w_is_get = (i_req.req_type == pol_pkg::REQ_GET);
    assign w_is_loc = (i_req.req_type == pol_pkg::REQ_LOCATE);
    assign w_is_clr = (i_req.req_type == pol_pkg::REQ_CLEAR);

    // Insert may go one past the end, but never into a full list.
    assign w_ins_ok = w_pos_nz && (w_pos_ext <= w_cnt_ext + 9'd1) && (r_count < MAX_CNT);
    // Delete and get need an occupied slot.
    assign w_rd_ok  = w_pos_nz && (w_pos_ext <= w_cnt_ext);

    always_comb begin
        case (i_req.req_type)
            pol_pkg::REQ_INSERT: w_ok = w_ins_ok;
            pol_pkg::REQ_DELETE: w_ok = w_rd_ok;
            pol_pkg::REQ_GET:    w_ok = w_rd_ok;
            pol_pkg::REQ_CLEAR:  w_ok = 1'b1;
            default:             w_ok = 1'b0;  // locate resolved later, unknown kinds fail
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (w_accept) begin
            if (w_is_ins && w_ins_ok) begin
                n_count = r_count + CNT_W'(1);
            end else if (w_is_del && w_rd_ok) begin
                n_count = r_count - CNT_W'(1);
            end else if (w_is_clr) begin
                n_count = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // ------------------------------------------------------------------
    // Cell chain
    // ------------------------------------------------------------------
    pol_pkg::t_cell_ctrl w_ctrl;

    logic [pol_pkg::DATA_W-1:0] w_data    [LIST_DEPTH];
    logic [pol_pkg::DATA_W-1:0] w_cell_rd [LIST_DEPTH];
    logic [LIST_DEPTH-1:0]      w_match;
    logic [pol_pkg::DATA_W-1:0] w_rd_or;

    always_comb begin
        w_ctrl.ins     = w_accept && w_is_ins && w_ins_ok;
        w_ctrl.del     = w_accept && w_is_del && w_rd_ok;
        w_ctrl.pos_idx = i_req.position - pol_pkg::POS_W'(1);
        w_ctrl.value   = i_req.item_value;
        w_ctrl.count   = pol_pkg::POS_W'(r_count);
    end

    for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
        logic [pol_pkg::DATA_W-1:0] w_left;
        logic [pol_pkg::DATA_W-1:0] w_right;

        if (g == 0) begin : g_head
            assign w_left = '0;
        end else begin : g_body_l
            assign w_left = w_data[g-1];
        end

        if (g == LIST_DEPTH - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_body_r
            assign w_right = w_data[g+1];
        end

        pol_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_ctrl    (w_ctrl),
            .i_left    (w_left),
            .i_right   (w_right),
            .o_data    (w_data[g]),
            .o_match   (w_match[g]),
            .o_rd_data (w_cell_rd[g])
        );
    end

    // Only the addressed cell drives a nonzero byte.
    always_comb begin
        w_rd_or = '0;
        for (int i = 0; i < LIST_DEPTH; i++) begin
            w_rd_or = w_rd_or | w_cell_rd[i];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: selected byte, match vector, new length
    // ------------------------------------------------------------------
    logic                       r_s1_valid;
    logic                       r_s1_loc;
    logic                       r_s1_ok;
    logic [pol_pkg::DATA_W-1:0] r_s1_rd;
    logic [LIST_DEPTH-1:0]      r_s1_match;
    logic [CNT_W-1:0]           r_s1_count;
    logic                       w_s1_adv;

    assign w_s1_adv    = r_s1_valid && (!o_rsp.valid || o_rsp.ready);
    assign i_req.ready = !r_s1_valid || w_s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_loc   <= w_is_loc;
            r_s1_ok    <= w_ok;
            r_s1_rd    <= ((w_is_del || w_is_get) && w_rd_ok) ? w_rd_or : '0;
            r_s1_match <= w_match;
            r_s1_count <= n_count;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: first match, output register
    // ------------------------------------------------------------------
    logic [pol_pkg::POS_W-1:0] w_first_pos;
    logic                      w_first_any;

    pol_first #(
        .WIDTH (LIST_DEPTH)
    ) u_first (
        .i_match (r_s1_match),
        .o_pos   (w_first_pos),
        .o_any   (w_first_any)
    );

    logic                       r_out_valid;
    logic                       r_out_ok;
    logic [pol_pkg::DATA_W-1:0] r_out_rd;
    logic [pol_pkg::POS_W-1:0]  r_out_found;
    logic [pol_pkg::POS_W-1:0]  r_out_len;
    logic                       r_out_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_out_ok    <= r_s1_loc ? w_first_any : r_s1_ok;
            r_out_rd    <= r_s1_rd;
            r_out_found <= r_s1_loc ? w_first_pos : '0;
            r_out_len   <= pol_pkg::POS_W'(r_s1_count);
            r_out_empty <= (r_s1_count == '0);
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.success        = r_out_ok;
    assign o_rsp.read_value     = r_out_rd;
    assign o_rsp.found_position = r_out_found;
    assign o_rsp.list_length    = r_out_len;
    assign o_rsp.list_empty     = r_out_empty;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `POL_ASSERT_NEVER(a_count_bound, i_clk, i_rst_n, r_count > MAX_CNT,
        "list count above depth")
    `POL_ASSERT(a_clear_empties, i_clk, i_rst_n, w_accept && w_is_clr |=> r_count == '0,
        "clear did not empty list")
    `POL_ASSERT(a_insert_grows, i_clk, i_rst_n, w_ctrl.ins |=> r_count == $past(r_count) + CNT_W'(1),
        "insert did not grow list")
    `POL_ASSERT(a_found_in_list, i_clk, i_rst_n, r_out_valid |-> r_out_found <= r_out_len,
        "found position beyond list length")

endmodule

// ----- hw/rtl/pol_cell.sv -----
// ----------------------------------------------------------------------------
// pol_cell
// One list slot: holds a byte, shifts with its neighbors, flags a key match.
// ----------------------------------------------------------------------------
module pol_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                        i_clk,
    input  pol_pkg::t_cell_ctrl         i_ctrl,
    input  logic [pol_pkg::DATA_W-1:0]  i_left,
    input  logic [pol_pkg::DATA_W-1:0]  i_right,
    output logic [pol_pkg::DATA_W-1:0]  o_data,
    output logic                        o_match,
    output logic [pol_pkg::DATA_W-1:0]  o_rd_data
);

    localparam logic [pol_pkg::POS_W-1:0] MY_IDX = pol_pkg::POS_W'(CELL_IDX);

    logic [pol_pkg::DATA_W-1:0] r_data;
    logic [pol_pkg::DATA_W-1:0] n_data;
    logic                       w_at_pos;

    assign w_at_pos = (i_ctrl.pos_idx == MY_IDX);

    always_comb begin
        n_data = r_data;
        if (i_ctrl.ins) begin
            if (w_at_pos) begin
                n_data = i_ctrl.value;
            end else if (MY_IDX > i_ctrl.pos_idx) begin
                n_data = i_left;
            end
        end else if (i_ctrl.del) begin
            if (MY_IDX >= i_ctrl.pos_idx) begin
                n_data = i_right;
            end
        end
    end

    // Slot contents need no reset; only slots below the count are observed.
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data    = r_data;
    assign o_match   = (MY_IDX < i_ctrl.count) && (r_data == i_ctrl.value);
    assign o_rd_data = w_at_pos ? r_data : '0;

endmodule

// ----- hw/rtl/pol_first.sv -----
// ----------------------------------------------------------------------------
// pol_first
// First-set-bit encoder: returns 1-based index of lowest match, 0 if none.
// ----------------------------------------------------------------------------
module pol_first #(
    parameter int WIDTH = 16
) (
    input  logic [WIDTH-1:0]             i_match,
    output logic [pol_pkg::POS_W-1:0]    o_pos,
    output logic                         o_any
);

    logic [WIDTH-1:0] w_lowest;

    // Isolate the lowest set bit, then encode it with an OR over all bits.
    assign w_lowest = i_match & (~i_match + WIDTH'(1));
    assign o_any    = |i_match;

    always_comb begin
        o_pos = '0;
        for (int i = 0; i < WIDTH; i++) begin
            if (w_lowest[i]) begin
                o_pos = o_pos | pol_pkg::POS_W'(i + 1);
            end
        end
    end

endmodule

// ----- verif/pol_list_checker.sv -----
// ----------------------------------------------------------------------------
// pol_list_checker
// Watches the request and response channels of the ordered list, keeps its
// own copy of the list, predicts one response per request transfer and
// compares every response transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module pol_list_checker #(
    parameter int LIST_DEPTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    pol_req_if   i_req_mon,
    pol_rsp_if   i_rsp_mon,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_list_len,
    output int   o_req_count,
    output int   o_rsp_count,
    output int   o_full_rejects
);
    timeunit 1ns;
    timeprecision 1ps;

    import pol_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic              success;
        logic [DATA_W-1:0] read_value;
        logic [POS_W-1:0]  found_position;
        logic [POS_W-1:0]  list_length;
        logic              list_empty;
    } t_list_rsp;

    logic [DATA_W-1:0] slots [LIST_DEPTH];
    int                fill;
    t_list_rsp         rsp_queue [$];

    // Applies one request to the shadow list and returns what the block owes.
    function automatic t_list_rsp apply_request(input logic [KIND_W-1:0] kind,
                                                input logic [POS_W-1:0]  pos,
                                                input logic [DATA_W-1:0] val);
        t_list_rsp r;
        int        k;
        r = '0;
        case (kind)
            REQ_INSERT: begin
                if (fill >= LIST_DEPTH) o_full_rejects++;
                if (pos >= 1 && pos <= fill + 1 && fill < LIST_DEPTH) begin
                    for (k = fill; k >= pos; k--) slots[k] = slots[k-1];
                    slots[pos-1] = val;
                    fill++;
                    r.success = 1'b1;
                end
            end
            REQ_DELETE: begin
                if (pos >= 1 && pos <= fill) begin
                    r.read_value = slots[pos-1];
                    for (k = pos; k < fill; k++) slots[k-1] = slots[k];
                    fill--;
                    r.success = 1'b1;
                end
            end
            REQ_GET: begin
                if (pos >= 1 && pos <= fill) begin
                    r.read_value = slots[pos-1];
                    r.success    = 1'b1;
                end
            end
            REQ_LOCATE: begin
                for (k = 0; k < fill; k++) begin
                    if (!r.success && slots[k] == val) begin
                        r.found_position = POS_W'(k + 1);
                        r.success        = 1'b1;
                    end
                end
            end
            REQ_CLEAR: begin
                fill      = 0;
                r.success = 1'b1;
            end
            default: ;
        endcase
        r.list_length = POS_W'(fill);
        r.list_empty  = (fill == 0);
        return r;
    endfunction

    task automatic flag(input string what, input logic [7:0] exp_v, input logic [7:0] act_v);
        o_fail_count++;
        if (o_fail_count <= REPORT_LIMIT)
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, exp_v, act_v);
    endtask

    always @(posedge i_clk) begin
        t_list_rsp want;
        if (!i_rst_n) begin
            fill = 0;
            rsp_queue.delete();
        end else begin
            // Response first: a response never belongs to a same-edge request.
            if (i_rsp_mon.valid && i_rsp_mon.ready) begin
                o_rsp_count++;
                if (rsp_queue.size() == 0) begin
                    flag("response with nothing outstanding, list_length",
                         8'h00, i_rsp_mon.list_length);
                end else begin
                    want = rsp_queue.pop_front();
                    if (i_rsp_mon.success !== want.success)
                        flag("success", want.success, i_rsp_mon.success);
                    if (i_rsp_mon.read_value !== want.read_value)
                        flag("read_value", want.read_value, i_rsp_mon.read_value);
                    if (i_rsp_mon.found_position !== want.found_position)
                        flag("found_position", want.found_position, i_rsp_mon.found_position);
                    if (i_rsp_mon.list_length !== want.list_length)
                        flag("list_length", want.list_length, i_rsp_mon.list_length);
                    if (i_rsp_mon.list_empty !== want.list_empty)
                        flag("list_empty", want.list_empty, i_rsp_mon.list_empty);
                end
            end
            if (i_req_mon.valid && i_req_mon.ready) begin
                o_req_count++;
                rsp_queue.push_back(apply_request(i_req_mon.req_type, i_req_mon.position,
                                                  i_req_mon.item_value));
            end
        end
        o_pending  = rsp_queue.size();
        o_list_len = fill;
    end

endmodule

// ----- verif/tb_positional_ordered_list.sv -----
// ----------------------------------------------------------------------------
// tb_positional_ordered_list
// Stimulus and verdict for the positional ordered list: a directed pass over
// the edge cases, then random request streams under four traffic mixes with
// long response back-pressure stretches and drain pauses. Checking is done
// by the checker instantiated next to the block.
// ----------------------------------------------------------------------------
module tb_positional_ordered_list;
    timeunit 1ns;
    timeprecision 1ps;

    import pol_pkg::*;

    localparam int LIST_DEPTH  = 16;
    localparam int PHASE_ITEMS = 450;   // four phases, about 1800 random transfers
    localparam int LONG_HOLD   = 60;    // cycles the receiver holds off under pressure
    localparam int STALL_LIMIT = 2000;  // watchdog: cycles without any transfer
    localparam int TAIL_CYCLES = 8;     // settle time before the verdict, for any stray response

    // Request codes the block does not know; it must answer them and leave the list alone.
    localparam logic [KIND_W-1:0] REQ_RSVD_FIRST = 3'd5;
    localparam logic [KIND_W-1:0] REQ_RSVD_LAST  = 3'd7;

    logic i_clk;
    logic i_rst_n;

    pol_req_if req_ch ();
    pol_rsp_if rsp_ch ();

    int fail_count;
    int pending;
    int list_len;
    int req_total;
    int rsp_total;
    int full_rejects;

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int hold_left      = 0;
    int idle_cycles    = 0;
    bit grow_mode      = 1'b1;

    positional_ordered_list #(
        .LIST_DEPTH (LIST_DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    pol_list_checker #(
        .LIST_DEPTH (LIST_DEPTH)
    ) chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_mon      (req_ch),
        .i_rsp_mon      (rsp_ch),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_list_len     (list_len),
        .o_req_count    (req_total),
        .o_rsp_count    (rsp_total),
        .o_full_rejects (full_rejects)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: random stalls per phase; a pending long hold-off takes priority
    // and is counted down here, one cycle per falling edge.
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    // Watchdog: the run is stuck if no transfer happens on either channel for too long.
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || !i_rst_n) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d responses outstanding",
                     idle_cycles, pending);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Offers one request; entered and left at a falling edge. Random source gaps
    // come first, so valid drops only when the sender actually idles.
    task automatic send_req(input logic [KIND_W-1:0] k, input logic [POS_W-1:0] p,
                            input logic [DATA_W-1:0] v);
        while ($urandom_range(99) < src_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= k;
        req_ch.position   <= p;
        req_ch.item_value <= v;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Sender goes quiet until every predicted response has been taken.
    task automatic pause_until_drained();
        req_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // Random request shaped by the current length: mostly positions near the
    // valid range, values from a narrow pool so locate hits and duplicates occur.
    task automatic make_item(output logic [KIND_W-1:0] k, output logic [POS_W-1:0] p,
                             output logic [DATA_W-1:0] v);
        int pick;
        pick = $urandom_range(99);
        if (grow_mode) begin
            if      (pick < 52) k = REQ_INSERT;
            else if (pick < 62) k = REQ_DELETE;
            else if (pick < 75) k = REQ_GET;
            else if (pick < 93) k = REQ_LOCATE;
            else if (pick < 95) k = REQ_CLEAR;
            else                k = KIND_W'($urandom_range(REQ_RSVD_FIRST, REQ_RSVD_LAST));
        end else begin
            if      (pick < 22) k = REQ_INSERT;
            else if (pick < 58) k = REQ_DELETE;
            else if (pick < 74) k = REQ_GET;
            else if (pick < 93) k = REQ_LOCATE;
            else if (pick < 96) k = REQ_CLEAR;
            else                k = KIND_W'($urandom_range(REQ_RSVD_FIRST, REQ_RSVD_LAST));
        end
        if ($urandom_range(99) < 85) p = POS_W'($urandom_range(0, list_len + 1));
        else                         p = POS_W'($urandom_range(0, 255));
        if ($urandom_range(99) < 60) v = DATA_W'($urandom_range(0, 7));
        else                         v = DATA_W'($urandom_range(0, 255));
    endtask

    initial begin
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] val;

        req_ch.valid      = 1'b0;
        req_ch.req_type   = REQ_INSERT;
        req_ch.position   = '0;
        req_ch.item_value = '0;
        i_rst_n           = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // ---- directed: empty-list rejects, bad insert positions ----
        send_req(REQ_GET,    8'd1, 8'h00);
        send_req(REQ_DELETE, 8'd1, 8'h00);
        send_req(REQ_INSERT, 8'd0, 8'hAA);
        send_req(REQ_INSERT, 8'd2, 8'h55);  // past the one-past-the-end slot of an empty list

        // Fill to capacity using front, end and middle positions; byte extremes first.
        for (int i = 0; i < LIST_DEPTH; i++) begin
            case (i % 3)
                0:       pos = 8'd1;
                1:       pos = POS_W'(i + 1);
                default: pos = POS_W'(i / 2 + 1);
            endcase
            if (i == 0)      val = 8'h00;
            else if (i == 1) val = 8'hFF;
            else             val = DATA_W'($urandom_range(1, 15));
            send_req(REQ_INSERT, pos, val);
        end

        send_req(REQ_INSERT, 8'd1,   8'h33);  // list full
        send_req(REQ_LOCATE, 8'd0,   8'hFF);  // present
        send_req(REQ_LOCATE, 8'hFF,  8'h80);  // absent
        send_req(REQ_GET,    8'hFF,  8'h00);  // far past the end
        send_req(REQ_DELETE, 8'd0,   8'h00);
        send_req(REQ_DELETE, POS_W'(LIST_DEPTH),     8'h00);  // last entry
        send_req(REQ_DELETE, POS_W'(LIST_DEPTH),     8'h00);  // now past the end
        send_req(REQ_RSVD_FIRST, 8'd1, 8'h12);
        send_req(REQ_CLEAR,  8'hFF,  8'hFF);

        // Sender holds back until the block has answered everything.
        pause_until_drained();

        // ---- random phases: no idling, source gaps, sink stalls, both ----
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1:       begin src_idle_pct = 69; sink_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  sink_stall_pct = 69; end
                default: begin src_idle_pct = 26; sink_stall_pct = 26; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Alternate growing and shrinking windows so full and empty both recur.
                grow_mode = ((n % 80) < 40);
                // Long receiver hold-off while requests keep coming: the block fills
                // its two response slots and must drop ready on the request side.
                if ((ph == 0 && n == 200) || (ph == 3 && n == 150)) hold_left = LONG_HOLD;
                make_item(kind, pos, val);
                send_req(kind, pos, val);
            end
            pause_until_drained();
        end

        // Let any stray response show up before the verdict.
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("Run covered %0d requests and %0d responses over four traffic mixes,",
                 req_total, rsp_total);
        $display("with %0d inserts refused on a full list and %0d field mismatches.",
                 full_rejects, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- positional_ordered_list.f -----
+incdir+hw/rtl
hw/rtl/pol_pkg.sv
hw/rtl/pol_req_if.sv
hw/rtl/pol_rsp_if.sv
hw/rtl/pol_cell.sv
hw/rtl/pol_first.sv
hw/rtl/positional_ordered_list.sv
verif/pol_list_checker.sv
verif/tb_positional_ordered_list.sv
